### rtl/core/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    // operand widths actually used by the datapath
    localparam int MOD_WIDTH = 32;
    localparam int EXP_WIDTH = 64;

    // bit counter for the serial multiplier, wide enough to hold MOD_WIDTH
    localparam int CNT_WIDTH = $clog2(MOD_WIDTH + 1);

    // input item
    typedef struct packed {
        logic [31:0] base_value;
        logic [63:0] exponent;
        logic [31:0] modulus;
    } mexp_in_t;

    // result item
    typedef struct packed {
        logic [31:0] residue;
        logic        bad_modulus;
    } mexp_out_t;

    // request into the serial modular multiplier
    typedef struct packed {
        logic                 go;
        logic [MOD_WIDTH-1:0] a;
        logic [MOD_WIDTH-1:0] b;
    } mexp_mul_req_t;

    // response from the serial modular multiplier
    typedef struct packed {
        logic                 done;
        logic [MOD_WIDTH-1:0] product;
    } mexp_mul_rsp_t;

endpackage

`default_nettype wire

### rtl/core/mexp_modmul.sv
`default_nettype none

// bit-serial modular multiplier: a * b mod m, one bit of b per cycle, msb first
// needs a < m; b may take any value
module mexp_modmul
    import mexp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mexp_mul_req_t        req,
    input  wire logic [MOD_WIDTH-1:0] m,
    output mexp_mul_rsp_t             rsp
);

    logic                 running_reg, running_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic [MOD_WIDTH-1:0] a_reg, a_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] r_reg, r_next;

    logic [MOD_WIDTH:0]   m_ext;
    logic [MOD_WIDTH:0]   dbl;
    logic [MOD_WIDTH:0]   dbl_red;
    logic [MOD_WIDTH:0]   sum;
    logic [MOD_WIDTH:0]   sum_red;

    // one step: r = (2r + bit * a) mod m, each half reduced by a single subtract
    always_comb
    begin
        m_ext   = {1'b0, m};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (b_reg[MOD_WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    end

    // load, step and finish control
    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        r_next       = r_reg;
        priority if (req.go)
        begin
            running_next = 1'b1;
            count_next   = CNT_WIDTH'(MOD_WIDTH);
            a_next       = req.a;
            b_next       = req.b;
            r_next       = '0;
        end
        else if (running_reg)
        begin
            r_next     = sum_red[MOD_WIDTH-1:0];
            b_next     = {b_reg[MOD_WIDTH-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_WIDTH'(1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
        else
        begin
            // idle: nothing to do
            running_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
        end
    end

    // operand and partial result shift registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

endmodule

`default_nettype wire

### rtl/core/modular_exponentiation.sv
`default_nettype none

// channel   | ports                           | transfer
// ----------+---------------------------------+-----------------------------------
// operands  | start, busy, operands           | rising edge with start high, busy low
// result    | done, result                    | the single cycle with done high
//
// square-and-multiply over the exponent, lsb first, on one serial multiplier.
// each modular product passes through issue, load and MOD_WIDTH steps, and each
// exponent bit passes through the scan state ST_STEP. a zero modulus reports in
// the cycle after the transfer. reset clears the control state only; the result
// cannot be stalled, and for a nonzero modulus busy stays high from the transfer
// in until the cycle in which done is high.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire mexp_in_t  operands,
    output logic           done,
    output mexp_out_t      result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_ACC,
        ST_SQUARE
    } state_t;

    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    mexp_out_t            result_reg, result_next;
    mexp_mul_req_t        req_reg, req_next;
    logic [MOD_WIDTH-1:0] m_reg, m_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] pw_reg, pw_next;

    mexp_mul_rsp_t        rsp;
    logic [MOD_WIDTH-1:0] m_in;
    logic [MOD_WIDTH-1:0] one_in;
    logic [EXP_WIDTH-1:0] exp_shift;
    logic                 exp_last;

    // shared serial multiplier
    mexp_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .m     (m_reg),
        .rsp   (rsp)
    );

    // operand views and exponent scan
    always_comb
    begin
        m_in      = operands.modulus[MOD_WIDTH-1:0];
        one_in    = (m_in == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
        exp_shift = exp_reg >> 1;
        exp_last  = (exp_shift == '0);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        req_next    = req_reg;
        req_next.go = 1'b0;
        m_next      = m_reg;
        exp_next    = exp_reg;
        acc_next    = acc_reg;
        pw_next     = pw_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (m_in == '0)
                    begin
                        done_next               = 1'b1;
                        result_next.residue     = '0;
                        result_next.bad_modulus = 1'b1;
                    end
                    else
                    begin
                        m_next     = m_in;
                        exp_next   = operands.exponent[EXP_WIDTH-1:0];
                        acc_next   = one_in;
                        req_next   = '{go: 1'b1, a: one_in,
                                       b: operands.base_value[MOD_WIDTH-1:0]};
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                // power starts as base mod m
                if (rsp.done)
                begin
                    pw_next    = rsp.product;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (exp_reg[0])
                begin
                    req_next   = '{go: 1'b1, a: acc_reg, b: pw_reg};
                    state_next = ST_ACC;
                end
                else
                begin
                    exp_next = exp_shift;
                    if (exp_last)
                    begin
                        done_next               = 1'b1;
                        result_next.residue     = 32'(acc_reg);
                        result_next.bad_modulus = 1'b0;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        req_next   = '{go: 1'b1, a: pw_reg, b: pw_reg};
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_ACC:
            begin
                if (rsp.done)
                begin
                    acc_next = rsp.product;
                    exp_next = exp_shift;
                    if (exp_last)
                    begin
                        done_next               = 1'b1;
                        result_next.residue     = 32'(rsp.product);
                        result_next.bad_modulus = 1'b0;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        req_next   = '{go: 1'b1, a: pw_reg, b: pw_reg};
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (rsp.done)
                begin
                    pw_next    = rsp.product;
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, registered outputs and multiplier request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            req_reg   <= req_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        m_reg      <= m_next;
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        pw_reg     <= pw_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### verif/modular_exponentiation_test.sv
module modular_exponentiation_test;
    import mexp_pkg::*;

    // cycles without any transfer before the run is abandoned
    localparam int unsigned QUIET_LIMIT = 40000;
    // cycles left for a stray result after the last expected one
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS = 120;

    // one queued operand set with its lead-in gap and drain request
    typedef struct {
        mexp_in_t    op;
        int unsigned lead_gap;
        bit          drain;
    } staged_op_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    mexp_in_t  operands = '0;
    logic      busy;
    logic      done;
    mexp_out_t result;

    staged_op_t  operand_backlog[$];
    mexp_out_t   residues_due[$];
    staged_op_t  held_op;
    bit          op_held = 1'b0;
    int unsigned lead_left = 0;
    logic        op_taken = 1'b0;
    bit          steady_feed = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    modular_exponentiation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always #1 clk = ~clk;

    // square-and-multiply over the exponent, lsb first
    function automatic mexp_out_t predict_power_residue(mexp_in_t op);
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] pw;
        logic [63:0] e;
        mexp_out_t   r;
        r = '0;
        m = 64'(op.modulus[MOD_WIDTH-1:0]);
        e = 64'(op.exponent[EXP_WIDTH-1:0]);
        if (m == 64'd0)
        begin
            r.bad_modulus = 1'b1;
            return r;
        end
        acc = 64'd1 % m;
        pw = 64'(op.base_value[MOD_WIDTH-1:0]) % m;
        while (e != 64'd0)
        begin
            if (e[0])
                acc = (acc * pw) % m;
            e = e >> 1;
            if (e != 64'd0)
                pw = (pw * pw) % m;
        end
        r.residue = acc[31:0];
        return r;
    endfunction

    task automatic queue_operands(input logic [31:0] b, input logic [63:0] e,
                                  input logic [31:0] m, input bit drain);
        staged_op_t s;
        s.op.base_value = b;
        s.op.exponent = e;
        s.op.modulus = m;
        s.lead_gap = steady_feed ? 0 : $urandom_range(0, 7);
        s.drain = drain;
        operand_backlog.push_back(s);
    endtask

    // driver: present the next operand set once the previous one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !op_taken))
        begin
            if (!op_held && operand_backlog.size() != 0)
            begin
                held_op = operand_backlog.pop_front();
                op_held = 1'b1;
                lead_left = held_op.lead_gap;
            end
            if (op_held && lead_left == 0 && !(held_op.drain && residues_due.size() != 0))
            begin
                operands <= held_op.op;
                start <= 1'b1;
                op_held = 1'b0;
            end
            else
            begin
                start <= 1'b0;
                if (op_held && lead_left != 0)
                    lead_left--;
            end
        end
    end

    // monitor: check results in order, record each operand transfer
    always @(posedge clk)
    begin
        mexp_out_t want;
        if (!rst_n)
            op_taken <= 1'b0;
        else
        begin
            op_taken <= start && !busy;
            if (done)
            begin
                if (residues_due.size() == 0)
                begin
                    $error("unexpected result: residue %0h bad_modulus %0b",
                           result.residue, result.bad_modulus);
                    mismatch_count++;
                end
                else
                begin
                    want = residues_due.pop_front();
                    if (result.residue !== want.residue)
                    begin
                        $error("residue: expected %0h, got %0h", want.residue, result.residue);
                        mismatch_count++;
                    end
                    if (result.bad_modulus !== want.bad_modulus)
                    begin
                        $error("bad_modulus: expected %0b, got %0b",
                               want.bad_modulus, result.bad_modulus);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                residues_due.push_back(predict_power_residue(operands));
        end
    end

    // watchdog on cycles with no transfer either way
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned sel;
        int unsigned w;
        logic [31:0] b;
        logic [63:0] e;
        logic [31:0] m;

        // directed corners
        queue_operands(32'd0, 64'd0, 32'd1, 1'b0);
        queue_operands(32'd0, 64'd0, 32'd7, 1'b0);
        queue_operands(32'd0, 64'd5, 32'd13, 1'b0);
        queue_operands(32'd9, 64'd0, 32'hFFFF_FFFF, 1'b0);
        queue_operands(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_operands(32'h1234_5678, 64'd77, 32'd0, 1'b0);
        queue_operands(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
        queue_operands(32'd0, 64'd0, 32'd0, 1'b0);
        queue_operands(32'hDEAD_BEEF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b0);
        queue_operands(32'hFFFF_FFFF, 64'd1, 32'd1000, 1'b0);
        queue_operands(32'd1000, 64'd3, 32'd1000, 1'b0);
        queue_operands(32'd3, 64'd10, 32'd2, 1'b0);
        queue_operands(32'd3, 64'h8000_0000_0000_0000, 32'hFFFF_FFFB, 1'b0);
        queue_operands(32'hFFFF_FFFE, 64'd2, 32'hFFFF_FFFF, 1'b0);
        queue_operands(32'hFFFF_FFFA, 64'd3, 32'hFFFF_FFFB, 1'b0);
        queue_operands(32'hFFFF_FFFA, 64'd4, 32'hFFFF_FFFB, 1'b0);
        // fermat: a^(p-1) = 1 mod p
        queue_operands(32'd3, 64'hFFFF_FFFA, 32'hFFFF_FFFB, 1'b0);
        queue_operands(32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0);
        queue_operands(32'h7FFF_FFFF, 64'h5555_5555_5555_5555, 32'h8000_0000, 1'b0);
        queue_operands(32'h8000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF, 1'b1);

        // random operand sets, mostly short exponents with some full width ones
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady_feed = (i >= 40 && i < 60);
            sel = $urandom_range(0, 99);
            if (sel < 3)
                m = 32'd0;
            else if (sel < 6)
                m = 32'd1;
            else if (sel < 20)
                m = $urandom_range(2, 255);
            else if (sel < 35)
                m = $urandom() | 32'h8000_0000;
            else
                m = $urandom();
            sel = $urandom_range(0, 99);
            if (sel < 8)
                b = 32'd0;
            else if (sel < 13)
                b = 32'hFFFF_FFFF;
            else if (sel < 23)
                b = $urandom_range(0, 15);
            else
                b = $urandom();
            sel = $urandom_range(0, 99);
            if (sel < 60)
                w = $urandom_range(0, 16);
            else if (sel < 80)
                w = $urandom_range(17, 40);
            else
                w = $urandom_range(41, 64);
            e = {$urandom(), $urandom()};
            if (w < 64)
                e = e & ~(64'hFFFF_FFFF_FFFF_FFFF << w);
            queue_operands(b, e, m, (i == 70) || ($urandom_range(0, 24) == 0));
        end

        // reset, released away from the sampling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every transfer in, then for every result
        while (operand_backlog.size() != 0 || op_held || start)
            @(negedge clk);
        while (residues_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### modular_exponentiation.f
rtl/core/mexp_pkg.sv
rtl/core/mexp_modmul.sv
rtl/core/modular_exponentiation.sv
verif/modular_exponentiation_test.sv
